// File: hdl/sfd_pkg.sv
// Shared constants and types for the SBUS frame decoder.
package sfd_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 25;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int NUM_CH      = 16;
  localparam int CH_BITS     = 11;
  localparam int CH_IDX_W    = $clog2(NUM_CH);
  localparam int DATA_BYTES  = 22;
  localparam int DATA_W      = DATA_BYTES * 8;

  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DATA_LAST  = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0] POS_FLAGS      = POS_W'(DATA_BYTES + 1);
  localparam logic [POS_W-1:0] POS_FOOTER     = POS_W'(FRAME_BYTES - 1);

  localparam logic [CH_IDX_W-1:0] CH_LAST = CH_IDX_W'(NUM_CH - 1);

  // Marker bytes and flag bit positions
  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;
  localparam int LOST_BIT = 2;
  localparam int FS_BIT   = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic                store_data;
    logic                store_flags;
    logic                emit;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                last;
  } sfd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr_match;
    logic ftr_match;
    logic out_free;
  } sfd_sts_t;

endpackage

// File: hdl/sfd_in_if.sv
// Byte request channel into the decoder.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sfd_out_if.sv
// Channel result request channel out of the decoder.
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        link_lost;
  logic        failsafe;
  logic        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output link_lost, output failsafe, output last_channel,
                  input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input link_lost, input failsafe, input last_channel,
                  output ready);
endinterface

// File: hdl/sbus_frame_decoder.sv
// SBUS frame decoder top level: 25-byte frames in, 16 channel results out.
//
//  channel   dir   payload                                       handshake
//  in_bus    in    rx_byte[7:0]                                  valid/ready
//  out_bus   out   channel_index, channel_value, link_lost,      valid/ready
//                  failsafe, last_channel
//
// Bytes are taken while the decoder is not emitting. After a closing byte
// with a good footer the input stalls while the 16 channels go out (one
// channel per cycle from the payload shifter while out_bus is free); the
// last result sits in the output register while the next byte is already taken.
// rst_n is synchronous: the decoder comes up hunting for a header.
module sbus_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_bus,
  sfd_out_if.source  out_bus
);

  sfd_pkg::sfd_cmd_t cmd;
  sfd_pkg::sfd_sts_t sts;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .rx_byte           (in_bus.rx_byte),
    .out_ready         (out_bus.ready),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_bus.valid),
    .out_channel_index (out_bus.channel_index),
    .out_channel_value (out_bus.channel_value),
    .out_link_lost     (out_bus.link_lost),
    .out_failsafe      (out_bus.failsafe),
    .out_last_channel  (out_bus.last_channel)
  );

endmodule

// File: hdl/sfd_datapath.sv
// Frame payload storage, channel unpacking shifter and result register.
module sfd_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            rx_byte,
  input  logic                  out_ready,
  input  sfd_pkg::sfd_cmd_t     cmd,
  output sfd_pkg::sfd_sts_t     sts,
  output logic                  out_valid,
  output logic [3:0]            out_channel_index,
  output logic [10:0]           out_channel_value,
  output logic                  out_link_lost,
  output logic                  out_failsafe,
  output logic                  out_last_channel
);

  logic [sfd_pkg::DATA_W-1:0] data_r, data_nxt;
  logic                       lost_r, fs_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [3:0]                 idx_r;
  logic [10:0]                val_r;
  logic                       olost_r, ofs_r, olast_r;

  // Bytes 1..22 shift in from the top so byte 1 lands at bit 0; each
  // emitted channel shifts the packed word down by one channel width.
  always_comb begin
    data_nxt = data_r;
    if (cmd.store_data) begin
      data_nxt = {rx_byte, data_r[sfd_pkg::DATA_W-1:8]};
    end else if (cmd.emit) begin
      data_nxt = data_r >> sfd_pkg::CH_BITS;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.store_flags) begin
      lost_r <= rx_byte[sfd_pkg::LOST_BIT];
      fs_r   <= rx_byte[sfd_pkg::FS_BIT];
    end
  end

  // Result register: loads when empty or being drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      idx_r   <= cmd.ch_idx;
      val_r   <= data_r[sfd_pkg::CH_BITS-1:0];
      olost_r <= lost_r;
      ofs_r   <= fs_r;
      olast_r <= cmd.last;
    end
  end

  assign sts.hdr_match = (rx_byte == sfd_pkg::HDR_BYTE);
  assign sts.ftr_match = (rx_byte == sfd_pkg::FTR_BYTE);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = val_r;
  assign out_link_lost     = olost_r;
  assign out_failsafe      = ofs_r;
  assign out_last_channel  = olast_r;

endmodule

// File: hdl/sfd_ctrl.sv
// Sync hunt, byte position tracking and channel emit sequencing.
module sfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_HUNT    = 3'b001,
    ST_COLLECT = 3'b010,
    ST_EMIT    = 3'b100
  } state_t;

  state_t                             state_r, state_nxt;
  logic [sfd_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic [sfd_pkg::CH_IDX_W-1:0]       ch_r, ch_nxt;
  logic                               accept;

  assign in_ready = (state_r != ST_EMIT);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    ch_nxt          = ch_r;
    cmd.store_data  = 1'b0;
    cmd.store_flags = 1'b0;
    cmd.emit        = 1'b0;
    cmd.ch_idx      = ch_r;
    cmd.last        = (ch_r == sfd_pkg::CH_LAST);
    case (state_r)
      ST_HUNT: begin
        if (accept && sts.hdr_match) begin
          state_nxt = ST_COLLECT;
          pos_nxt   = sfd_pkg::POS_DATA_FIRST;
        end
      end
      ST_COLLECT: begin
        if (accept) begin
          cmd.store_data  = (pos_r >= sfd_pkg::POS_DATA_FIRST) &&
                            (pos_r <= sfd_pkg::POS_DATA_LAST);
          cmd.store_flags = (pos_r == sfd_pkg::POS_FLAGS);
          pos_nxt         = pos_r + 1'b1;
          // closing byte: footer decides emit or drop
          if (pos_r == sfd_pkg::POS_FOOTER) begin
            pos_nxt   = '0;
            ch_nxt    = '0;
            state_nxt = sts.ftr_match ? ST_EMIT : ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          ch_nxt   = ch_r + 1'b1;
          if (ch_r == sfd_pkg::CH_LAST) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule
